// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Field widths, operation and status codes, and cell control bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int VALUE_W     = 32;
	localparam int PRI_IN_W    = 8;
	localparam int COUNT_OUT_W = 5;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// one shared bundle broadcast to every cell
	typedef struct packed {
		logic push;   // accepted push that fits
		logic pop;    // accepted pop of a held entry
	} cell_ctrl_t;

endpackage : spq_pkg
`default_nettype wire

// File: rtl/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: bounded priority queue kept in sorted order
// A row of cells holds the entries head first; a push inserts behind all
// entries of lower or equal priority, a pop shifts the row toward the head.
//
//  channel   dir  tdata / tuser                               transfer
//  s_axis    in   user: opcode; data: value, priority         one push/pop
//  m_axis    out  data: head value/priority, count, empty,    one result
//                 status
//
// One item per cycle unless the output stalls: every cell decides its next entry
// in the same cycle, so the rate is set by the cell compare and the result register.
// A result is registered in the cycle after its item is taken; a stalled output
// holds the result and stops intake only while the result is still waiting.
// Reset clears the count and the output valid; cell contents are not reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH   = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,   // item_value[31:0], item_priority[39:32]
	input  wire logic        s_axis_tuser,   // opcode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata    // head_value[31:0], head_priority[39:32],
	                                         // entry_count[44:40], queue_empty[45],
	                                         // status[47:46]
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0]            count_q, count_d;
	logic                     take;
	opcode_t                  op;
	logic [VALUE_W-1:0]       in_val;
	logic [PRIORITY_BITS-1:0] in_pri;
	logic                     full, empty;
	cell_ctrl_t               ctrl;
	status_t                  status_d;

	logic [VALUE_W-1:0]       cell_val [QUEUE_DEPTH];
	logic [PRIORITY_BITS-1:0] cell_pri [QUEUE_DEPTH];
	logic [VALUE_W-1:0]       cell_val_d [QUEUE_DEPTH];
	logic [PRIORITY_BITS-1:0] cell_pri_d [QUEUE_DEPTH];
	logic                     cell_keep [QUEUE_DEPTH];

	logic                     out_valid_q;
	logic [VALUE_W-1:0]       head_value_q;
	logic [PRI_IN_W-1:0]      head_priority_q;
	logic [COUNT_OUT_W-1:0]   entry_count_q;
	logic                     queue_empty_q;
	status_t                  status_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign op            = opcode_t'(s_axis_tuser);
	assign in_val        = s_axis_tdata[31:0];
	assign in_pri        = PRIORITY_BITS'(s_axis_tdata[39:32]);

	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		ctrl.push = 1'b0;
		ctrl.pop  = 1'b0;
		count_d   = count_q;
		status_d  = ST_OK;
		if (take) begin
			unique case (op)
				OP_PUSH: begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						ctrl.push = 1'b1;
						count_d   = count_q + CW'(1);
					end
				end
				OP_POP: begin
					if (empty) begin
						status_d = ST_EMPTY;
					end else begin
						ctrl.pop = 1'b1;
						count_d  = count_q - CW'(1);
					end
				end
				default: status_d = ST_OK;
			endcase
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                     lk;
		logic [VALUE_W-1:0]       lv, rv;
		logic [PRIORITY_BITS-1:0] lp, rp;

		if (i == 0) begin : g_first
			assign lk = 1'b1;
			assign lv = in_val;
			assign lp = in_pri;
		end else begin : g_mid
			assign lk = cell_keep[i-1];
			assign lv = cell_val[i-1];
			assign lp = cell_pri[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign rv = cell_val[i];
			assign rp = cell_pri[i];
		end else begin : g_inner
			assign rv = cell_val[i+1];
			assign rp = cell_pri[i+1];
		end

		spq_cell #(
			.PRIORITY_BITS(PRIORITY_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occupied  (count_q > CW'(i)),
			.new_val   (in_val),
			.new_pri   (in_pri),
			.left_keep (lk),
			.left_val  (lv),
			.left_pri  (lp),
			.right_val (rv),
			.right_pri (rp),
			.keep      (cell_keep[i]),
			.val_q     (cell_val[i]),
			.pri_q     (cell_pri[i]),
			.val_d     (cell_val_d[i]),
			.pri_d     (cell_pri_d[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload: head after the operation, zero when empty
	always_ff @(posedge clk) begin
		if (take) begin
			if (count_d == '0) begin
				head_value_q    <= '0;
				head_priority_q <= '0;
				queue_empty_q   <= 1'b1;
			end else begin
				head_value_q    <= cell_val_d[0];
				head_priority_q <= PRI_IN_W'(cell_pri_d[0]);
				queue_empty_q   <= 1'b0;
			end
			entry_count_q <= COUNT_OUT_W'(count_d);
			status_q      <= status_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {status_q, queue_empty_q, entry_count_q,
	                        head_priority_q, head_value_q};

endmodule : sorted_priority_queue_core
`default_nettype wire

// File: rtl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry; on a push it keeps, takes the new entry or takes the left
// neighbor's entry; on a pop it takes the right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
#(
	parameter int PRIORITY_BITS = 8
) (
	input  wire logic                     clk,
	input  wire cell_ctrl_t               ctrl,
	input  wire logic                     occupied,
	input  wire logic [VALUE_W-1:0]       new_val,
	input  wire logic [PRIORITY_BITS-1:0] new_pri,
	input  wire logic                     left_keep,
	input  wire logic [VALUE_W-1:0]       left_val,
	input  wire logic [PRIORITY_BITS-1:0] left_pri,
	input  wire logic [VALUE_W-1:0]       right_val,
	input  wire logic [PRIORITY_BITS-1:0] right_pri,
	output logic                          keep,
	output logic [VALUE_W-1:0]            val_q,
	output logic [PRIORITY_BITS-1:0]      pri_q,
	output logic [VALUE_W-1:0]            val_d,
	output logic [PRIORITY_BITS-1:0]      pri_d
);

	// equal priorities stay ahead of the new entry
	assign keep = occupied && (pri_q <= new_pri);

	always_comb begin
		val_d = val_q;
		pri_d = pri_q;
		if (ctrl.push && !keep) begin
			if (left_keep) begin
				val_d = new_val;
				pri_d = new_pri;
			end else begin
				val_d = left_val;
				pri_d = left_pri;
			end
		end else if (ctrl.pop) begin
			val_d = right_val;
			pri_d = right_pri;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
		pri_q <= pri_d;
	end

endmodule : spq_cell
`default_nettype wire
